### rtl/dq_pkg.sv
`default_nettype none

package dq_pkg;

    // default sizing
    localparam int DEFAULT_DEPTH      = 16;
    localparam int DEFAULT_DATA_WIDTH = 32;

    // operation codes carried by i_action
    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_PUSH_BACK  = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_POP_BACK   = 3'd4
    } t_action;

    // status codes reported with every result
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_PUSH_FULL = 2'd1,
        ST_POP_EMPTY = 2'd2
    } t_status;

    // per-cycle command broadcast along one row of cells
    typedef struct packed {
        logic shift_in;     // every cell takes its lower neighbor, cell 0 takes push data
        logic shift_out;    // every cell but the last takes its upper neighbor, the last keeps its value
        logic write_tail;   // the cell at the fill position takes push data
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/double_ended_queue.sv
`default_nettype none

// Bounded double-ended queue built from two rows of shifting cells.
// One row keeps the elements in order from the front, the other in order
// from the back, so the front and back elements always sit in cell 0 of
// their row and no row is ever searched.
// Command channel: an operation (none, push front, push back, pop front,
// pop back) plus push data is transferred at a rising edge with start high
// and busy low. busy stays low: every row shifts or fills as the operation
// is taken, so one operation is taken each clock.
// Result channel: one result per operation, shown for exactly one cycle
// with o_result_valid high, in the cycle after the transfer (throughput
// 1 per clock). It carries the front and back elements (zero
// when empty), the count, the empty and full flags, and the status.
// A push on a full queue or a pop on an empty one changes nothing and is
// flagged in the status; unknown action codes act as none.
// The receiver cannot stall; a result not taken in its cycle is lost.
// Reset (i_rst_n low, synchronous) empties the queue and clears the strobe;
// element storage is not cleared and needs no clearing pass.
module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = dq_pkg::DEFAULT_DATA_WIDTH,
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [2:0]            i_action,
    input  wire logic [DATA_WIDTH-1:0] i_push_data,
    output logic                       o_result_valid,
    output logic      [DATA_WIDTH-1:0] o_front_value,
    output logic      [DATA_WIDTH-1:0] o_back_value,
    output logic      [CW-1:0]         o_element_count,
    output logic                       o_is_empty,
    output logic                       o_is_full,
    output logic      [1:0]            o_status
);
    import dq_pkg::*;

    logic          r_valid;
    logic          n_valid;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_status       r_status;
    t_status       n_status;

    t_cell_ctl             w_front_ctl;
    t_cell_ctl             w_back_ctl;
    logic [DATA_WIDTH-1:0] w_front_head;
    logic [DATA_WIDTH-1:0] w_back_head;
    logic                  w_transfer;
    logic                  w_full;
    logic                  w_empty;

    assign busy       = 1'b0;
    assign w_transfer = start && !busy;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    // decode the operation into row commands and the new count
    always_comb begin
        n_valid     = w_transfer;
        n_count     = r_count;
        n_status    = r_status;
        w_front_ctl = '0;
        w_back_ctl  = '0;
        if (w_transfer) begin
            n_status = ST_DONE;
            case (t_action'(i_action))
                ACT_PUSH_FRONT: begin
                    if (w_full) begin
                        n_status = ST_PUSH_FULL;
                    end else begin
                        w_front_ctl.shift_in  = 1'b1;
                        w_back_ctl.write_tail = 1'b1;
                        n_count               = r_count + CW'(1);
                    end
                end
                ACT_PUSH_BACK: begin
                    if (w_full) begin
                        n_status = ST_PUSH_FULL;
                    end else begin
                        w_front_ctl.write_tail = 1'b1;
                        w_back_ctl.shift_in    = 1'b1;
                        n_count                = r_count + CW'(1);
                    end
                end
                ACT_POP_FRONT: begin
                    if (w_empty) begin
                        n_status = ST_POP_EMPTY;
                    end else begin
                        w_front_ctl.shift_out = 1'b1;
                        n_count               = r_count - CW'(1);
                    end
                end
                ACT_POP_BACK: begin
                    if (w_empty) begin
                        n_status = ST_POP_EMPTY;
                    end else begin
                        w_back_ctl.shift_out = 1'b1;
                        n_count              = r_count - CW'(1);
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_count  <= '0;
            r_status <= ST_DONE;
        end else begin
            r_valid  <= n_valid;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    // row ordered from the front
    dq_chain #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW)
    ) u_front_row (
        .i_clk       (i_clk),
        .i_ctl       (w_front_ctl),
        .i_count     (r_count),
        .i_push_data (i_push_data),
        .o_head_data (w_front_head)
    );

    // row ordered from the back
    dq_chain #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW)
    ) u_back_row (
        .i_clk       (i_clk),
        .i_ctl       (w_back_ctl),
        .i_count     (r_count),
        .i_push_data (i_push_data),
        .o_head_data (w_back_head)
    );

    // result outputs
    assign o_result_valid  = r_valid;
    assign o_front_value   = w_empty ? '0 : w_front_head;
    assign o_back_value    = w_empty ? '0 : w_back_head;
    assign o_element_count = r_count;
    assign o_is_empty      = w_empty;
    assign o_is_full       = w_full;
    assign o_status        = r_status;

    // checks
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_transfer |=> o_result_valid)
        else $error("missing result after transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_transfer |=> !o_result_valid)
        else $error("result without transfer");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("count above capacity");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_is_empty |-> (o_front_value == '0) && (o_back_value == '0))
        else $error("nonzero value on empty queue");

    a_dropped_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_status != ST_DONE) |-> $stable(r_count))
        else $error("flagged operation changed the count");

endmodule

`default_nettype wire

### rtl/dq_cell.sv
`default_nettype none

module dq_cell #(
    parameter int DATA_WIDTH = dq_pkg::DEFAULT_DATA_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire dq_pkg::t_cell_ctl     i_ctl,
    input  wire logic                  i_tail_hit,
    input  wire logic [DATA_WIDTH-1:0] i_prev_data,
    input  wire logic [DATA_WIDTH-1:0] i_next_data,
    input  wire logic [DATA_WIDTH-1:0] i_push_data,
    output logic      [DATA_WIDTH-1:0] o_data
);
    import dq_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // pick the new content: shift away from cell 0, toward cell 0, or fill
    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_in) begin
            n_data = i_prev_data;
        end else if (i_ctl.shift_out) begin
            n_data = i_next_data;
        end else if (i_ctl.write_tail && i_tail_hit) begin
            n_data = i_push_data;
        end
    end

    // element storage, no reset needed
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### rtl/dq_chain.sv
`default_nettype none

module dq_chain #(
    parameter int DEPTH      = dq_pkg::DEFAULT_DEPTH,
    parameter int DATA_WIDTH = dq_pkg::DEFAULT_DATA_WIDTH,
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  wire logic                  i_clk,
    input  wire dq_pkg::t_cell_ctl     i_ctl,
    input  wire logic [CW-1:0]         i_count,
    input  wire logic [DATA_WIDTH-1:0] i_push_data,
    output logic      [DATA_WIDTH-1:0] o_head_data
);
    import dq_pkg::*;

    logic [DATA_WIDTH-1:0] w_data [DEPTH];

    // row of cells, cell 0 holds the element at the open end of this row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_prev;
        logic [DATA_WIDTH-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = i_push_data;
        end else begin : g_mid
            assign w_prev = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_up
            assign w_next = w_data[g+1];
        end

        dq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_tail_hit  (i_count == CW'(g)),
            .i_prev_data (w_prev),
            .i_next_data (w_next),
            .i_push_data (i_push_data),
            .o_data      (w_data[g])
        );
    end

    assign o_head_data = w_data[0];

endmodule

`default_nettype wire
